@@ rtl/core/rect_largest_first_sorter_assert.svh @@
// Assertion macros for the rectangle sorter.
// Included by the top level; no dependencies on other files.
`ifndef RECT_LARGEST_FIRST_SORTER_ASSERT_SVH
`define RECT_LARGEST_FIRST_SORTER_ASSERT_SVH
`ifndef SYNTHESIS
`define RLFS_ASSERT_IMP(lbl, clk, rstn, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ant) |-> (cons)) \
        else $error("rect sorter check failed");
`define RLFS_ASSERT_NXT(lbl, clk, rstn, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ant) |=> (cons)) \
        else $error("rect sorter check failed");
`else
`define RLFS_ASSERT_IMP(lbl, clk, rstn, ant, cons)
`define RLFS_ASSERT_NXT(lbl, clk, rstn, ant, cons)
`endif
`endif

@@ rtl/core/rlfs_pkg.sv @@
// Shared types and widths for the rectangle sorter.
// No dependencies; used by every module of the block.
package rlfs_pkg;

    localparam int TAG_W  = 16;
    localparam int DIM_W  = 15;
    localparam int AREA_W = 2 * DIM_W;

    // One rectangle with its precomputed sort keys.
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;
        logic [DIM_W-1:0]  major;
        logic [AREA_W-1:0] area;
    } rlfs_rect_t;

    typedef struct packed {
        logic       valid;
        rlfs_rect_t rect;
    } rlfs_slot_t;

    // Chain-wide control: insert the broadcast rectangle, or shift toward the head.
    typedef struct packed {
        logic ins;
        logic pop;
    } rlfs_ctrl_t;

endpackage

@@ rtl/core/rlfs_prep.sv @@
// Input conditioning for the rectangle sorter: clamps the sides and forms the keys.
// Depends on rlfs_pkg.
module rlfs_prep #(
    parameter int MAX_DIM = 16384
) (
    input  logic [rlfs_pkg::TAG_W-1:0] tag,
    input  logic [rlfs_pkg::DIM_W-1:0] rect_width,
    input  logic [rlfs_pkg::DIM_W-1:0] rect_height,
    output rlfs_pkg::rlfs_rect_t       rect,
    output logic                       keep
);

    localparam logic [rlfs_pkg::DIM_W+1:0] DIM_LIM = (rlfs_pkg::DIM_W + 2)'(MAX_DIM);
    localparam logic [rlfs_pkg::DIM_W-1:0] DIM_CLAMP = rlfs_pkg::DIM_W'(MAX_DIM);

    logic [rlfs_pkg::DIM_W-1:0] w_c;
    logic [rlfs_pkg::DIM_W-1:0] h_c;

    always_comb begin
        w_c = ({2'b00, rect_width} > DIM_LIM) ? DIM_CLAMP : rect_width;
        h_c = ({2'b00, rect_height} > DIM_LIM) ? DIM_CLAMP : rect_height;
        rect.tag   = tag;
        rect.w     = w_c;
        rect.h     = h_c;
        rect.major = (w_c > h_c) ? w_c : h_c;
        rect.area  = rlfs_pkg::AREA_W'(w_c) * rlfs_pkg::AREA_W'(h_c);
        // A rectangle with a zero side is dropped without raising overflow.
        keep = (rect_width != '0) && (rect_height != '0);
    end

endmodule

@@ rtl/core/rlfs_cell.sv @@
// One slot of the insertion chain: compares the broadcast rectangle with its own
// and takes the new one, its left neighbor's or its right neighbor's. Uses rlfs_pkg.
module rlfs_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rlfs_pkg::rlfs_ctrl_t ctrl,
    input  rlfs_pkg::rlfs_rect_t new_rect,
    input  rlfs_pkg::rlfs_slot_t left_q,
    input  logic                 left_gt,
    input  rlfs_pkg::rlfs_slot_t right_q,
    output rlfs_pkg::rlfs_slot_t q,
    output logic                 gt
);

    logic                 valid_reg;
    logic                 valid_next;
    rlfs_pkg::rlfs_rect_t rect_reg;
    rlfs_pkg::rlfs_rect_t rect_next;

    assign q.valid = valid_reg;
    assign q.rect  = rect_reg;

    // Strictly larger wins; equal keys leave the earlier arrival in front.
    assign gt = !valid_reg
             || (new_rect.major > rect_reg.major)
             || ((new_rect.major == rect_reg.major) && (new_rect.area > rect_reg.area));

    always_comb begin
        valid_next = valid_reg;
        rect_next  = rect_reg;
        if (ctrl.pop) begin
            valid_next = right_q.valid;
            rect_next  = right_q.rect;
        end else if (ctrl.ins) begin
            if (left_gt) begin
                valid_next = left_q.valid;
                rect_next  = left_q.rect;
            end else if (gt) begin
                valid_next = 1'b1;
                rect_next  = new_rect;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        rect_reg <= rect_next;
    end

endmodule

@@ rtl/core/rect_largest_first_sorter.sv @@
// Rectangle sorter, largest first, built as a chain of insertion cells.
// Rectangles arrive one per transaction on the s_ channel; s_tlast closes a set.
// Order: larger max(width, height) first, then larger area, then arrival order.
// Every accepted rectangle is inserted in the cycle after its transaction, so the
// fill phase takes one rectangle per cycle. When the transaction with s_tlast has
// been inserted, the chain drains from its head onto the m_ channel, one result
// per cycle while m_tready is high; m_tlast marks the smallest rectangle and
// m_tuser is high on every result of a set that lost rectangles to a full chain.
// The first result is loaded into the output register once the closing transaction
// has been inserted and the drain has begun; s_tready stays low from that
// transaction until the drain has finished. A set with nothing stored gives no
// result. Rectangles with a zero side are dropped silently, sides above MAX_DIM
// are clamped. A stalled receiver holds the result register and freezes the drain.
// Reset (aresetn low, synchronous) empties the chain and the output register.
// Depends on rlfs_pkg, rlfs_prep, rlfs_cell and rect_largest_first_sorter_assert.svh.
`include "rect_largest_first_sorter_assert.svh"

module rect_largest_first_sorter #(
    parameter int MAX_RECTS = 64,
    parameter int MAX_DIM   = 16384
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // tag[15:0], rect_width[30:16], rect_height[45:31], zeros
    input  logic        s_tlast,   // final_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_tag[15:0], out_width[30:16], out_height[45:31], zeros
    output logic        m_tlast,   // end_of_run
    output logic        m_tuser    // overflowed
);

    localparam logic ST_FILL  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic state_reg;
    logic state_next;

    rlfs_pkg::rlfs_rect_t prep_rect;
    logic                 prep_keep;

    logic                 a_valid_reg;
    logic                 a_valid_next;
    rlfs_pkg::rlfs_rect_t a_rect_reg;
    logic                 a_keep_reg;
    logic                 a_last_reg;

    logic ovf_reg;
    logic ovf_next;

    logic                        m_valid_reg;
    logic                        m_valid_next;
    logic [rlfs_pkg::TAG_W-1:0]  out_tag_reg;
    logic [rlfs_pkg::DIM_W-1:0]  out_w_reg;
    logic [rlfs_pkg::DIM_W-1:0]  out_h_reg;
    logic                        out_last_reg;
    logic                        out_ovf_reg;

    rlfs_pkg::rlfs_ctrl_t ctrl;
    rlfs_pkg::rlfs_slot_t slot_q  [MAX_RECTS];
    logic                 slot_gt [MAX_RECTS];
    logic [MAX_RECTS-1:0] slot_valid;
    logic                 full;
    logic                 s_acc;

    rlfs_prep #(
        .MAX_DIM (MAX_DIM)
    ) u_prep (
        .tag         (s_tdata[15:0]),
        .rect_width  (s_tdata[30:16]),
        .rect_height (s_tdata[45:31]),
        .rect        (prep_rect),
        .keep        (prep_keep)
    );

    genvar gi;
    generate
        for (gi = 0; gi < MAX_RECTS; gi++) begin : g_cell
            rlfs_pkg::rlfs_slot_t left_q;
            rlfs_pkg::rlfs_slot_t right_q;
            logic                 left_gt;
            if (gi == 0) begin : g_head
                assign left_q  = '0;
                assign left_gt = 1'b0;
            end else begin : g_body
                assign left_q  = slot_q[gi-1];
                assign left_gt = slot_gt[gi-1];
            end
            if (gi == MAX_RECTS - 1) begin : g_tail
                assign right_q = '0;
            end else begin : g_inner
                assign right_q = slot_q[gi+1];
            end
            rlfs_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (ctrl),
                .new_rect (a_rect_reg),
                .left_q   (left_q),
                .left_gt  (left_gt),
                .right_q  (right_q),
                .q        (slot_q[gi]),
                .gt       (slot_gt[gi])
            );
            assign slot_valid[gi] = slot_q[gi].valid;
        end
    endgenerate

    assign full     = slot_valid[MAX_RECTS-1];
    assign s_tready = (state_reg == ST_FILL) && !(a_valid_reg && a_last_reg);
    assign s_acc    = s_tvalid && s_tready;

    always_comb begin
        ctrl.ins = (state_reg == ST_FILL) && a_valid_reg && a_keep_reg && !full;
        ctrl.pop = (state_reg == ST_DRAIN) && slot_valid[0] && (!m_valid_reg || m_tready);

        a_valid_next = s_acc;
        m_valid_next = ctrl.pop || (m_valid_reg && !m_tready);

        state_next = state_reg;
        ovf_next   = ovf_reg;
        unique case (state_reg)
            ST_FILL: begin
                if (a_valid_reg && a_keep_reg && full) begin
                    ovf_next = 1'b1;
                end
                if (a_valid_reg && a_last_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!slot_valid[0]) begin
                    state_next = ST_FILL;
                    ovf_next   = 1'b0;
                end
            end
            default: begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_FILL;
            a_valid_reg <= 1'b0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            a_valid_reg <= a_valid_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
        if (s_acc) begin
            a_rect_reg <= prep_rect;
            a_keep_reg <= prep_keep;
            a_last_reg <= s_tlast;
        end
        if (ctrl.pop) begin
            out_tag_reg  <= slot_q[0].rect.tag;
            out_w_reg    <= slot_q[0].rect.w;
            out_h_reg    <= slot_q[0].rect.h;
            out_last_reg <= !slot_valid[1];
            out_ovf_reg  <= ovf_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_h_reg, out_w_reg, out_tag_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;

    // Occupied slots always form an unbroken run from the head of the chain.
    `RLFS_ASSERT_IMP(a_slots_packed, aclk, aresetn, 1'b1,
        (slot_valid & (slot_valid + MAX_RECTS'(1))) == '0)
    // Popping the last stored rectangle leaves the chain empty.
    `RLFS_ASSERT_NXT(a_drain_ends, aclk, aresetn, ctrl.pop && !slot_valid[1], !slot_valid[0])
    // While filling, a recorded overflow means the chain is full.
    `RLFS_ASSERT_IMP(a_ovf_full, aclk, aresetn, ovf_reg && (state_reg == ST_FILL), full)

endmodule

@@ tb/tb_rect_largest_first_sorter.sv @@
// Self-checking testbench for rect_largest_first_sorter: directed, capacity, back-pressure
// and random rectangle sets are checked against an insertion-sort predictor.
// Depends on rlfs_pkg and the rect_largest_first_sorter RTL.
`timescale 1ns / 1ps

module tb_rect_largest_first_sorter;

    localparam int TAG_W         = rlfs_pkg::TAG_W;
    localparam int DIM_W         = rlfs_pkg::DIM_W;
    localparam int MAX_RECTS     = 64;
    localparam int MAX_DIM       = 16384;
    localparam int STALL_LIMIT   = 5000;
    localparam int RX_HOLD_LONG  = 150;
    localparam int DRAIN_CYCLES  = 20;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } stored_rect_t;

    typedef struct packed {
        stored_rect_t rect;
        logic         end_of_run;
        logic         overflowed;
    } sorted_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // tag[15:0], rect_width[30:16], rect_height[45:31], zeros
    logic        s_tlast  = 1'b0; // final_item
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // out_tag[15:0], out_width[30:16], out_height[45:31], zeros
    logic        m_tlast;         // end_of_run
    logic        m_tuser;         // overflowed

    // Predictor state: the set collected so far, kept in sorted order.
    stored_rect_t   held_rects[$];
    logic           held_overflow = 1'b0;
    sorted_result_t sorted_results_q[$];

    int fail_count  = 0;
    int idle_cycles = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold     = 0;

    rect_largest_first_sorter #(
        .MAX_RECTS(MAX_RECTS),
        .MAX_DIM  (MAX_DIM)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic bit outranks(stored_rect_t a, stored_rect_t b);
        int unsigned major_a, major_b, area_a, area_b;
        major_a = (a.w > a.h) ? a.w : a.h;
        major_b = (b.w > b.h) ? b.w : b.h;
        area_a  = int'(a.w) * int'(a.h);
        area_b  = int'(b.w) * int'(b.h);
        return (major_a > major_b) || (major_a == major_b && area_a > area_b);
    endfunction

    function automatic void take_rect(logic [TAG_W-1:0] tag, logic [DIM_W-1:0] w_in,
                                      logic [DIM_W-1:0] h_in, logic is_final);
        stored_rect_t   r;
        sorted_result_t res;
        int             pos;
        r.tag = tag;
        r.w   = (w_in > MAX_DIM) ? DIM_W'(MAX_DIM) : w_in;
        r.h   = (h_in > MAX_DIM) ? DIM_W'(MAX_DIM) : h_in;
        if (w_in != 0 && h_in != 0) begin
            if (held_rects.size() < MAX_RECTS) begin
                // Equal keys stop the walk, so earlier arrivals stay ahead.
                pos = held_rects.size();
                while (pos > 0 && outranks(r, held_rects[pos-1]))
                    pos--;
                held_rects.insert(pos, r);
            end else begin
                held_overflow = 1'b1;
            end
        end
        if (is_final) begin
            foreach (held_rects[i]) begin
                res.rect       = held_rects[i];
                res.end_of_run = (i == held_rects.size() - 1);
                res.overflowed = held_overflow;
                sorted_results_q.push_back(res);
            end
            held_rects.delete();
            held_overflow = 1'b0;
        end
    endfunction

    function automatic void check_result();
        sorted_result_t exp_res;
        sorted_result_t got;
        got.rect.tag   = m_tdata[15:0];
        got.rect.w     = m_tdata[30:16];
        got.rect.h     = m_tdata[45:31];
        got.end_of_run = m_tlast;
        got.overflowed = m_tuser;
        if (sorted_results_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("ERROR: unexpected result tag=%0d w=%0d h=%0d last=%0b ovf=%0b",
                         got.rect.tag, got.rect.w, got.rect.h, got.end_of_run,
                         got.overflowed);
        end else begin
            exp_res = sorted_results_q.pop_front();
            if (got.rect.tag !== exp_res.rect.tag || got.rect.w !== exp_res.rect.w ||
                got.rect.h !== exp_res.rect.h || got.end_of_run !== exp_res.end_of_run ||
                got.overflowed !== exp_res.overflowed) begin
                fail_count++;
                if (fail_count <= 10)
                    $display({"ERROR: expected tag=%0d w=%0d h=%0d last=%0b ovf=%0b, ",
                              "got tag=%0d w=%0d h=%0d last=%0b ovf=%0b"},
                             exp_res.rect.tag, exp_res.rect.w, exp_res.rect.h,
                             exp_res.end_of_run, exp_res.overflowed,
                             got.rect.tag, got.rect.w, got.rect.h, got.end_of_run,
                             got.overflowed);
            end
        end
    endfunction

    // Monitor: predicts on input transactions, checks output transactions,
    // and ends the run if the handshakes stop moving.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                take_rect(s_tdata[15:0], s_tdata[30:16], s_tdata[45:31], s_tlast);
            if (m_tvalid && m_tready)
                check_result();
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when a test requests one.
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic send_rect(input logic [TAG_W-1:0] tag, input logic [DIM_W-1:0] w,
                             input logic [DIM_W-1:0] h, input logic is_final);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, h, w, tag};
        s_tlast  <= is_final;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sorted_results_q.size() != 0)
            @(posedge aclk);
    endtask

    // Half the sides are small so that ties in both keys are common.
    function automatic logic [DIM_W-1:0] rand_dim();
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9: return DIM_W'($urandom_range(1, 6));
            10, 11, 12, 13, 14, 15:       return DIM_W'($urandom_range(1, MAX_DIM));
            16:                           return DIM_W'(MAX_DIM);
            17:                           return DIM_W'($urandom_range(MAX_DIM + 1, 32767));
            18:                           return DIM_W'($urandom_range(1, 32767));
            default:                      return '0;
        endcase
    endfunction

    task automatic test_directed();
        // Single rectangle, smallest sides.
        send_rect(16'h0000, 15'd1, 15'd1, 1'b1);
        // Equal keys in both orientations, area tie-break, clamping and zero sides.
        send_rect(16'h0001, 15'd4, 15'd2, 1'b0);
        send_rect(16'h0002, 15'd2, 15'd4, 1'b0);
        send_rect(16'h0003, 15'd4, 15'd1, 1'b0);
        send_rect(16'h0004, 15'd3, 15'd3, 1'b0);
        send_rect(16'h0005, 15'd4, 15'd4, 1'b0);
        send_rect(16'hFFFF, 15'd16384, 15'd16384, 1'b0);
        send_rect(16'h0006, 15'h7FFF, 15'd1, 1'b0);
        send_rect(16'h0007, 15'd16384, 15'd1, 1'b0);
        send_rect(16'h0008, 15'd0, 15'd5, 1'b0);
        send_rect(16'h0009, 15'd5, 15'd0, 1'b0);
        send_rect(16'h5555, 15'h5555, 15'h2AAA, 1'b0);
        send_rect(16'hAAAA, 15'h2AAA, 15'h5555, 1'b1);
        // A set whose only item has a zero side gives no result.
        send_rect(16'h000A, 15'd0, 15'd0, 1'b1);
        // A dropped item still closes the set.
        send_rect(16'h000B, 15'd7, 15'd3, 1'b0);
        send_rect(16'h000C, 15'd0, 15'd9, 1'b1);
        // Both sides above the limit, then only the width.
        send_rect(16'h000D, 15'h7FFF, 15'h7FFF, 1'b1);
        send_rect(16'h000E, 15'd16385, 15'd2, 1'b1);
        wait_drained();
    endtask

    task automatic test_capacity();
        // The chain fills exactly, three more are dropped, then a set must be clean again.
        for (int i = 0; i < MAX_RECTS + 3; i++)
            send_rect(TAG_W'($urandom), rand_dim() | 15'd1, rand_dim() | 15'd1,
                      i == MAX_RECTS + 2);
        send_rect(16'h1234, 15'd5, 15'd6, 1'b0);
        send_rect(16'h4321, 15'd6, 15'd5, 1'b1);
        wait_drained();
    endtask

    task automatic test_backpressure();
        // The receiver holds off while several sets are offered back to back,
        // so the drain freezes and the input channel stalls behind it.
        @(posedge aclk);
        rx_hold = RX_HOLD_LONG;
        for (int s = 0; s < 3; s++)
            for (int i = 0; i < 6; i++)
                send_rect(TAG_W'($urandom), rand_dim(), rand_dim(), i == 5);
        wait_drained();
    endtask

    task automatic test_random_sets(input int n_items);
        int sent = 0;
        int set_len;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 85) begin
                set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
                                                      : $urandom_range(1, 8);
                for (int i = 0; i < set_len; i++)
                    send_rect(TAG_W'($urandom), rand_dim(), rand_dim(), i == set_len - 1);
                sent += set_len;
            end else begin
                send_rect(TAG_W'($urandom), DIM_W'($urandom), DIM_W'($urandom),
                          1'($urandom));
                sent++;
            end
        end
        // Close any set left open by a noise transaction.
        send_rect(TAG_W'($urandom), rand_dim(), rand_dim(), 1'b1);
        wait_drained();
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 16;
        rx_idle_pct = 74;
        test_directed();
        test_capacity();
        test_backpressure();

        tx_idle_pct = 74;
        rx_idle_pct = 16;
        test_random_sets(30);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_sets(30);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && sorted_results_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
